[sv/srt_pkg.sv]
// srt_pkg: shared types and constants for the signed radix-to-text converter.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srt_pkg;

  localparam int RADIX_W       = 5;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_ADDR_W    = 2;
  localparam int SYM_W         = 8;
  localparam int TABLE_SLOTS   = 16;
  localparam int TABLE_IDX_W   = 4;
  localparam int DIV_STEP_BITS = 8;

  localparam logic [SYM_W-1:0] SIGN_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SIGN_MINUS = 8'h2D;

  localparam logic [CFG_ADDR_W-1:0] CFG_RADIX     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DIGITS_LO = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_DIGITS_HI = 2'd2;

  localparam logic [RADIX_W-1:0]    RADIX_RST     = 5'd10;
  localparam logic [CFG_DATA_W-1:0] DIGITS_LO_RST = 64'h3736353433323130;
  localparam logic [CFG_DATA_W-1:0] DIGITS_HI_RST = 64'h4645444342413938;

  typedef struct packed {
    logic load;
    logic div_step;
    logic rd_first;
    logic put_sign;
    logic put_digit;
  } srt_cmd_t;

  typedef struct packed {
    logic div_last;
    logic quot_zero;
    logic neg;
    logic out_free;
    logic ptr_zero;
  } srt_stat_t;

endpackage

`default_nettype wire

[sv/srt_cfg.sv]
// srt_cfg: radix and symbol table registers, plus the table validity check.
// Depends on srt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srt_cfg
  import srt_pkg::*;
#(
  parameter int MAX_RADIX = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]          cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]          cfg_wdata,
  output logic      [RADIX_W-1:0]             radix,
  output logic      [TABLE_SLOTS*SYM_W-1:0]   sym_table,
  output logic                                table_ok
);

  logic [RADIX_W-1:0]    radix_r;
  logic [CFG_DATA_W-1:0] digits_lo_r;
  logic [CFG_DATA_W-1:0] digits_hi_r;
  logic                  table_ok_r;
  logic                  table_ok_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= RADIX_RST;
      digits_lo_r <= DIGITS_LO_RST;
      digits_hi_r <= DIGITS_HI_RST;
      table_ok_r  <= 1'b0;
    end else begin
      table_ok_r <= table_ok_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_RADIX:     radix_r     <= cfg_wdata[RADIX_W-1:0];
          CFG_DIGITS_LO: digits_lo_r <= cfg_wdata;
          CFG_DIGITS_HI: digits_hi_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign sym_table = {digits_hi_r, digits_lo_r};

  // radix must lie in 2..MAX_RADIX; in-use symbols must be distinct and must not be a sign
  always_comb begin
    logic [SYM_W-1:0] si;
    logic [SYM_W-1:0] sj;
    table_ok_nxt = (radix_r >= RADIX_W'(2)) && (radix_r <= RADIX_W'(MAX_RADIX));
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      si = sym_table[i*SYM_W +: SYM_W];
      if ((RADIX_W'(i) < radix_r) && ((si == SIGN_PLUS) || (si == SIGN_MINUS))) begin
        table_ok_nxt = 1'b0;
      end
      for (int j = i + 1; j < TABLE_SLOTS; j++) begin
        sj = sym_table[j*SYM_W +: SYM_W];
        if ((RADIX_W'(j) < radix_r) && (si == sj)) begin
          table_ok_nxt = 1'b0;
        end
      end
    end
  end

  assign radix    = radix_r;
  assign table_ok = table_ok_r;

endmodule

`default_nettype wire

[sv/srt_ctrl.sv]
// srt_ctrl: sequencing state machine; accepts items and drives datapath commands.
// Depends on srt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srt_ctrl
  import srt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire logic      table_ok,
  input  wire srt_stat_t stat,
  output srt_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_QTEST,
    S_SIGN,
    S_PUT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = table_ok ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_QTEST;
        end
      end
      S_QTEST: begin
        if (stat.quot_zero) begin
          cmd.rd_first = 1'b1;
          state_nxt    = stat.neg ? S_SIGN : S_PUT;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_SIGN: begin
        if (stat.out_free) begin
          cmd.put_sign = 1'b1;
          state_nxt    = S_PUT;
        end
      end
      S_PUT: begin
        if (stat.out_free) begin
          cmd.put_digit = 1'b1;
          if (stat.ptr_zero) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[sv/srt_dp.sv]
// srt_dp: magnitude divider (8 quotient bits a cycle), digit store and output register.
// Depends on srt_pkg; commanded by srt_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module srt_dp
  import srt_pkg::*;
#(
  parameter int MAX_RADIX  = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [VALUE_BITS-1:0]        in_value,
  input  wire logic [RADIX_W-1:0]           radix,
  input  wire logic [TABLE_SLOTS*SYM_W-1:0] sym_table,
  input  wire srt_cmd_t                     cmd,
  output srt_stat_t                         stat,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic      [SYM_W-1:0]             out_symbol,
  output logic                              out_last
);

  localparam int NSTEP = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int WB    = NSTEP * DIV_STEP_BITS;
  localparam int SCW   = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam int DW    = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int AW    = $clog2(VALUE_BITS);
  localparam int CW    = $clog2(VALUE_BITS + 1);

  logic                     neg_r;
  logic [WB-1:0]            work_r;
  logic [WB-1:0]            work_nxt;
  logic [DW-1:0]            rem_r;
  logic [DW-1:0]            rem_nxt;
  logic [DIV_STEP_BITS-1:0] qbits;
  logic [SCW-1:0]           step_r;
  logic [CW-1:0]            cnt_r;
  logic [AW-1:0]            ptr_r;
  logic [CW-1:0]            cnt_m1;
  logic [AW-1:0]            mem_raddr;
  logic                     mem_we;
  logic                     mem_re;
  logic [DW-1:0]            mem [VALUE_BITS];
  logic [DW-1:0]            rd_data_r;
  logic [VALUE_BITS-1:0]    mag;
  logic                     div_last;
  logic                     ptr_zero;
  logic                     out_free;
  logic [TABLE_IDX_W-1:0]   sidx;
  logic [SYM_W-1:0]         digit_sym;
  logic                     out_valid_r;
  logic [SYM_W-1:0]         out_sym_r;
  logic                     out_last_r;

  assign mag = in_value[VALUE_BITS-1] ? (~in_value + 1'b1) : in_value;

  // restoring division, one quotient bit per inner step
  always_comb begin
    logic [DW:0]   r2;
    logic [DW-1:0] rr;
    rr    = rem_r;
    qbits = '0;
    for (int k = 0; k < DIV_STEP_BITS; k++) begin
      r2 = {rr, work_r[WB-1-k]};
      if (RADIX_W'(r2) >= radix) begin
        r2 = r2 - radix[DW:0];
        qbits[DIV_STEP_BITS-1-k] = 1'b1;
      end
      rr = r2[DW-1:0];
    end
    rem_nxt  = rr;
    work_nxt = (work_r << DIV_STEP_BITS) | WB'(qbits);
  end

  assign div_last  = (step_r == SCW'(NSTEP - 1));
  assign ptr_zero  = (ptr_r == '0);
  assign out_free  = !out_valid_r || out_tready;
  assign cnt_m1    = cnt_r - CW'(1);
  assign mem_we    = cmd.div_step && div_last;
  assign mem_re    = cmd.rd_first || (cmd.put_digit && !ptr_zero);
  assign mem_raddr = cmd.rd_first ? cnt_m1[AW-1:0] : (ptr_r - AW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.load) begin
      step_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.div_step) begin
      if (div_last) begin
        step_r <= '0;
        cnt_r  <= cnt_r + CW'(1);
      end else begin
        step_r <= step_r + SCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r  <= in_value[VALUE_BITS-1];
      work_r <= WB'(mag);
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      work_r <= work_nxt;
      rem_r  <= div_last ? '0 : rem_nxt;
    end
    if (cmd.rd_first) begin
      ptr_r <= cnt_m1[AW-1:0];
    end else if (cmd.put_digit) begin
      ptr_r <= ptr_r - AW'(1);
    end
  end

  // digits stored least significant first, read back in reverse
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[AW-1:0]] <= rem_nxt;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign sidx      = TABLE_IDX_W'(rd_data_r);
  assign digit_sym = sym_table[sidx*SYM_W +: SYM_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.put_sign || cmd.put_digit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_sign) begin
      out_sym_r  <= SIGN_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.put_digit) begin
      out_sym_r  <= digit_sym;
      out_last_r <= ptr_zero;
    end
  end

  assign stat.div_last  = div_last;
  assign stat.quot_zero = (work_r == '0);
  assign stat.neg       = neg_r;
  assign stat.out_free  = out_free;
  assign stat.ptr_zero  = ptr_zero;

  assign out_tvalid = out_valid_r;
  assign out_symbol = out_sym_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

[sv/signed_radix_to_text.sv]
// signed_radix_to_text: top level; writes a signed integer as text in a set radix.
// Depends on srt_pkg, srt_cfg, srt_ctrl, srt_dp.
//
//   port group | dir | carries
//   in_*       | in  | one signed value per item
//   out_*      | out | one character per item, tlast on the final one
//   cfg_*      | in  | register writes: 0 radix, 1 digits 0-7, 2 digits 8-15
//
// One value at a time. A value is accepted, then the table is checked; each digit
// then comes from a pass of division steps over the whole value in the remainder
// unit (8 quotient bits a cycle) and a zero test, and symbols leave at one a cycle
// while the output is not stalled. An invalid table ends the item with no output.
// Reset is synchronous and restores the default decimal table. The output
// register lets the next value be accepted while the last character waits.
`timescale 1ns / 1ps
`default_nettype none

module signed_radix_to_text
  import srt_pkg::*;
#(
  parameter int MAX_RADIX  = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [VALUE_BITS-1:0] value, upper bits zero padding
  input  wire logic [((VALUE_BITS+7)/8)*8-1:0] in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [7:0] symbol
  output logic      [SYM_W-1:0]      out_tdata,
  output logic                       out_tlast
);

  logic [RADIX_W-1:0]           radix;
  logic [TABLE_SLOTS*SYM_W-1:0] sym_table;
  logic                         table_ok;
  srt_cmd_t                     cmd;
  srt_stat_t                    stat;

  srt_cfg #(
    .MAX_RADIX (MAX_RADIX)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .radix     (radix),
    .sym_table (sym_table),
    .table_ok  (table_ok)
  );

  srt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .table_ok  (table_ok),
    .stat      (stat),
    .cmd       (cmd)
  );

  srt_dp #(
    .MAX_RADIX  (MAX_RADIX),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_value   (in_tdata[VALUE_BITS-1:0]),
    .radix      (radix),
    .sym_table  (sym_table),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_symbol (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

`default_nettype wire

[sv/srt_chk.sv]
// srt_chk: port-level checks for signed_radix_to_text, attached by bind.
// Depends on srt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srt_chk
  import srt_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic [((VALUE_BITS+7)/8)*8-1:0]   in_tdata,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [SYM_W-1:0]                  out_tdata,
  input wire logic                              out_tlast
);

  logic in_seen;
  assign in_seen = ^in_tdata | 1'b1;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output item changed");

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata == SIGN_MINUS) |-> !out_tlast)
    else $error("minus sign marked as final character");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_seen |=> !in_tready)
    else $error("item taken while previous one still in work");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind signed_radix_to_text srt_chk #(
  .VALUE_BITS (VALUE_BITS)
) u_srt_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
